### hdl/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types, constants and constant tables of the stain color
// deconvolution pipeline: optical density table and output level thresholds.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = COEF_W - 4;
  localparam int DENS_FRAC = 8;
  localparam int DENS_W    = 17;
  localparam int PROD_W    = COEF_W + DENS_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int PROD_FRAC = COEF_FRAC + DENS_FRAC;
  localparam int RND_SHIFT = PROD_FRAC - 16;
  localparam int T_W       = 26;
  localparam int LVL_W     = 8;
  localparam int LUT_N     = 256;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = COEF_W;

  typedef logic signed [DENS_W-1:0] dens_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [T_W-1:0]    tval_t;

  typedef dens_t dens_tab_t [LUT_N];
  typedef tval_t thr_tab_t [LUT_N];

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_H0 = 3'd0,
    REG_COEF_H1 = 3'd1,
    REG_COEF_H2 = 3'd2,
    REG_COEF_E0 = 3'd3,
    REG_COEF_E1 = 3'd4,
    REG_COEF_E2 = 3'd5,
    REG_SWAP    = 3'd6
  } cfg_reg_t;

  // per-stage load enables
  typedef struct packed {
    logic dens;
    logic prod;
    logic sum;
    logic prep;
    logic srch;
    logic outp;
  } pipe_en_t;

  // log2 in unsigned q.32, truncated bit by bit
  function automatic logic [63:0] log2_q32(input int unsigned x);
    int unsigned xv;
    int          k;
    logic [63:0] y;
    logic [63:0] r;
    xv = (x == 0) ? 1 : x;
    k  = 0;
    for (int i = 0; i < 31; i++) begin
      if ((xv >> (k + 1)) != 0) k++;
    end
    y = 64'(xv) << (31 - k);
    r = 64'(k) << 32;
    for (int i = 31; i >= 0; i--) begin
      y = (y * y) >> 31;
      if (y >= 64'h1_0000_0000) begin
        y    = y >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  localparam longint LOG2_255 = longint'(log2_q32(255));
  localparam longint DENS_DIV = 2 * LOG2_255;
  localparam longint EXP_K    = longint'(255) <<< 16;

  function automatic dens_tab_t build_dens();
    dens_tab_t tab;
    longint    lv;
    longint    a;
    longint    q;
    for (int v = 0; v < LUT_N; v++) begin
      lv = longint'(log2_q32(v + 1));
      a  = 255 * (LOG2_255 - lv) * (longint'(1) <<< (DENS_FRAC + 1)) + LOG2_255;
      q  = a / DENS_DIV;
      if ((a % DENS_DIV) != 0 && a < 0) q = q - 1;
      tab[v] = DENS_W'(q);
    end
    return tab;
  endfunction

  // smallest t with floor(t*log2(255)/(255<<16)) >= log2(2o-1)-1
  function automatic thr_tab_t build_thr();
    thr_tab_t tab;
    longint   thr;
    longint   a;
    longint   q;
    tab[0] = '0;
    for (int o = 1; o < LUT_N; o++) begin
      thr = longint'(log2_q32(2 * o - 1)) - (longint'(1) <<< 32);
      a   = thr * EXP_K;
      q   = a / LOG2_255;
      if ((a % LOG2_255) != 0 && a > 0) q = q + 1;
      tab[o] = T_W'(q);
    end
    return tab;
  endfunction

  localparam dens_tab_t DENS_TAB = build_dens();
  localparam thr_tab_t  THR_TAB  = build_thr();

endpackage

### hdl/scd_density.sv
// ----------------------------------------------------------------------------
// scd_density
// Optical density lookup for the three channels, with optional order reversal.
// ----------------------------------------------------------------------------
module scd_density
  import scd_pkg::*;
(
  input  logic             clk,
  input  pipe_en_t         en,
  input  logic             swap,
  input  logic [LVL_W-1:0] chan_a,
  input  logic [LVL_W-1:0] chan_b,
  input  logic [LVL_W-1:0] chan_c,
  output dens_t            dens [3]
);

  dens_t dens_r [3];

  always_ff @(posedge clk) begin
    if (en.dens) begin
      if (swap) begin
        dens_r[0] <= DENS_TAB[chan_c];
        dens_r[1] <= DENS_TAB[chan_b];
        dens_r[2] <= DENS_TAB[chan_a];
      end else begin
        dens_r[0] <= DENS_TAB[chan_a];
        dens_r[1] <= DENS_TAB[chan_b];
        dens_r[2] <= DENS_TAB[chan_c];
      end
    end
  end

  assign dens = dens_r;

endmodule

### hdl/scd_dot.sv
// ----------------------------------------------------------------------------
// scd_dot
// One stain row: three registered products, then a registered sum.
// ----------------------------------------------------------------------------
module scd_dot
  import scd_pkg::*;
(
  input  logic     clk,
  input  pipe_en_t en,
  input  coef_t    coef [3],
  input  dens_t    dens [3],
  output sum_t     sum
);

  logic signed [PROD_W-1:0] prod_r [3];
  sum_t                     sum_r;

  always_ff @(posedge clk) begin
    if (en.prod) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= PROD_W'(coef[k]) * PROD_W'(dens[k]);
      end
    end
    if (en.sum) begin
      sum_r <= SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]);
    end
  end

  assign sum = sum_r;

endmodule

### hdl/scd_level.sv
// ----------------------------------------------------------------------------
// scd_level
// Concentration to intensity: rounding, saturation and a two-stage binary
// search of the exponent thresholds, then the output register.
// ----------------------------------------------------------------------------
module scd_level
  import scd_pkg::*;
(
  input  logic             clk,
  input  pipe_en_t         en,
  input  sum_t             sum,
  output logic [LVL_W-1:0] level
);

  typedef enum logic [1:0] {
    LV_SEARCH,
    LV_FULL,
    LV_ZERO
  } lv_mode_t;

  localparam sum_t  SAT_LIM = SUM_W'(longint'(288) <<< PROD_FRAC);
  localparam sum_t  RND_ADD = SUM_W'(longint'(1) <<< (RND_SHIFT - 1));
  localparam tval_t T_FULL  = T_W'(longint'(255) <<< 16);

  lv_mode_t         mode_nxt;
  lv_mode_t         mode_r;
  lv_mode_t         mode2_r;
  logic [SUM_W-1:0] p_rnd;
  tval_t            t_nxt;
  tval_t            t_r;
  tval_t            t2_r;
  logic [LVL_W-1:0] hi_nxt;
  logic [LVL_W-1:0] hi_r;
  logic [LVL_W-1:0] lo_nxt;
  logic [LVL_W-1:0] cand_h;
  logic [LVL_W-1:0] cand_l;
  logic [LVL_W-1:0] level_nxt;
  logic [LVL_W-1:0] level_r;

  always_comb begin
    if (sum <= 0) begin
      mode_nxt = LV_FULL;
    end else if (sum >= SAT_LIM) begin
      mode_nxt = LV_ZERO;
    end else begin
      mode_nxt = LV_SEARCH;
    end
    p_rnd = sum + RND_ADD;
    t_nxt = T_FULL - signed'(p_rnd[RND_SHIFT+T_W-1:RND_SHIFT]);
  end

  // upper four result bits
  always_comb begin
    hi_nxt = '0;
    cand_h = '0;
    for (int b = LVL_W - 1; b >= LVL_W / 2; b--) begin
      cand_h = hi_nxt | (LVL_W'(1) << b);
      if (t_r >= THR_TAB[cand_h]) hi_nxt = cand_h;
    end
  end

  // lower four result bits
  always_comb begin
    lo_nxt = hi_r;
    cand_l = '0;
    for (int b = LVL_W / 2 - 1; b >= 0; b--) begin
      cand_l = lo_nxt | (LVL_W'(1) << b);
      if (t2_r >= THR_TAB[cand_l]) lo_nxt = cand_l;
    end
    case (mode2_r)
      LV_FULL:   level_nxt = '1;
      LV_ZERO:   level_nxt = '0;
      LV_SEARCH: level_nxt = lo_nxt;
      default:   level_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.prep) begin
      mode_r <= mode_nxt;
      t_r    <= t_nxt;
    end
    if (en.srch) begin
      mode2_r <= mode_r;
      t2_r    <= t_r;
      hi_r    <= hi_nxt;
    end
    if (en.outp) begin
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule

### hdl/stain_color_deconvolution_unit.sv
// ----------------------------------------------------------------------------
// stain_color_deconvolution_unit
// Hematoxylin and eosin separation of one 8-bit three-channel pixel per cycle.
//
//   port group   direction   flow control       payload
//   in_          input       in_valid/in_stall    in_chan_a/b/c
//   out_         output      out_valid/out_stall  out_hema_level, out_eosin_level
//   cfg_         input       cfg_we               cfg_index, cfg_data
//
// six register stages: density lookup, products, sums, rounding, two search
// steps. one pixel per cycle is sustained while the output is not stalled;
// a bubble stage fills even while stalled.
// out_stall ripples back through full stages only; in_stall rises when all
// six stages hold data and the output is stalled.
// synchronous reset empties the pipeline and clears the config registers.
// ----------------------------------------------------------------------------
module stain_color_deconvolution_unit
  import scd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [LVL_W-1:0]     in_chan_a,
  input  logic [LVL_W-1:0]     in_chan_b,
  input  logic [LVL_W-1:0]     in_chan_c,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LVL_W-1:0]     out_hema_level,
  output logic [LVL_W-1:0]     out_eosin_level,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int NSTG = 6;

  coef_t           coef_h_r [3];
  coef_t           coef_e_r [3];
  logic            swap_r;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] vin;
  pipe_en_t        en;
  dens_t           dens [3];
  sum_t            sum_h;
  sum_t            sum_e;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        coef_h_r[k] <= '0;
        coef_e_r[k] <= '0;
      end
      swap_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_H0: coef_h_r[0] <= cfg_data;
        REG_COEF_H1: coef_h_r[1] <= cfg_data;
        REG_COEF_H2: coef_h_r[2] <= cfg_data;
        REG_COEF_E0: coef_e_r[0] <= cfg_data;
        REG_COEF_E1: coef_e_r[1] <= cfg_data;
        REG_COEF_E2: coef_e_r[2] <= cfg_data;
        REG_SWAP:    swap_r      <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // pipeline flow control
  always_comb begin
    vin = {vld_r[NSTG-2:0], in_valid};
    rdy[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    en.dens = rdy[0] && vin[0];
    en.prod = rdy[1] && vin[1];
    en.sum  = rdy[2] && vin[2];
    en.prep = rdy[3] && vin[3];
    en.srch = rdy[4] && vin[4];
    en.outp = rdy[5] && vin[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (rdy[i]) vld_r[i] <= vin[i];
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NSTG-1];

  scd_density u_density (
    .clk    (clk),
    .en     (en),
    .swap   (swap_r),
    .chan_a (in_chan_a),
    .chan_b (in_chan_b),
    .chan_c (in_chan_c),
    .dens   (dens)
  );

  scd_dot u_dot_h (
    .clk  (clk),
    .en   (en),
    .coef (coef_h_r),
    .dens (dens),
    .sum  (sum_h)
  );

  scd_dot u_dot_e (
    .clk  (clk),
    .en   (en),
    .coef (coef_e_r),
    .dens (dens),
    .sum  (sum_e)
  );

  scd_level u_level_h (
    .clk   (clk),
    .en    (en),
    .sum   (sum_h),
    .level (out_hema_level)
  );

  scd_level u_level_e (
    .clk   (clk),
    .en    (en),
    .sum   (sum_e),
    .level (out_eosin_level)
  );

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&vld_r) && out_stall))
    else $error("input stalled with a free stage");

  a_full_and_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    ((&vld_r) && out_stall) |-> in_stall)
    else $error("input taken into a full blocked pipeline");

  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("transfer lost at the first stage");

  a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(vld_r) == $past($countones(vld_r))
      + $past(int'(in_valid && !in_stall)) - $past(int'(out_valid && !out_stall))))
    else $error("pipeline occupancy mismatch");
`endif

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// stain_color_deconvolution_unit testbench
// Streams pixels through the hematoxylin/eosin separation pipeline. A
// scoreboard computes the expected stain levels with its own optical density
// and exponent arithmetic and checks every output transfer in order. The run
// covers several coefficient sets, both channel orders and random idle and
// stall patterns on both sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam cfg_reg_t WEIGHT_REG [6] = '{REG_COEF_H0, REG_COEF_H1, REG_COEF_H2,
                                           REG_COEF_E0, REG_COEF_E1, REG_COEF_E2};
  localparam coef_t COEF_MIN    = {1'b1, {(COEF_W-1){1'b0}}};
  localparam coef_t COEF_MAX    = {1'b0, {(COEF_W-1){1'b1}}};
  localparam int    LATENCY     = 6;
  localparam int    PHASES      = 6;
  localparam int    PHASE_ITEMS = 225;
  localparam int    HOLD_AT     = 350;
  localparam int    HOLD_CYCLES = 60;
  localparam int    DRAIN_LIMIT = 4000;

  typedef struct {
    logic [LVL_W-1:0] hema;
    logic [LVL_W-1:0] eosin;
  } stain_levels_t;

  class stain_level_board;
    coef_t         weight [6];
    bit            swap_chan;
    longint        dens_lut [LUT_N];
    longint        thr_lut [LUT_N];
    longint        log255;
    stain_levels_t expected_levels [$];
    int            errors;

    function new();
      longint lv;
      longint num;
      foreach (weight[i]) weight[i] = '0;
      swap_chan = 1'b0;
      errors    = 0;
      log255    = longint'(log2_fix(255));
      for (int v = 0; v < LUT_N; v++) begin
        lv          = longint'(log2_fix(v + 1));
        num         = 255 * (log255 - lv);
        dens_lut[v] = floor_div((num <<< (DENS_FRAC + 1)) + log255, 2 * log255);
      end
      thr_lut[0] = 0;
      for (int o = 1; o < LUT_N; o++)
        thr_lut[o] = longint'(log2_fix(2 * o - 1)) - (longint'(1) <<< 32);
    endfunction

    // log2 in unsigned q.32, one fraction bit per squaring
    function logic [63:0] log2_fix(int unsigned x);
      int unsigned xv;
      int          msb;
      logic [63:0] m;
      logic [63:0] acc;
      xv  = (x == 0) ? 1 : x;
      msb = 0;
      for (int i = 1; i < 32; i++) begin
        if ((xv >> i) != 0) msb = i;
      end
      m   = 64'(xv) << (31 - msb);
      acc = 64'(msb) << 32;
      for (int i = 31; i >= 0; i--) begin
        m = (m * m) >> 31;
        if (m[32]) begin
          m      = m >> 1;
          acc[i] = 1'b1;
        end
      end
      return acc;
    endfunction

    function longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
    endfunction

    function logic [LVL_W-1:0] to_level(longint p);
      longint           conc;
      longint           t;
      longint           e;
      logic [LVL_W-1:0] lo;
      logic [LVL_W-1:0] cand;
      if (p <= 0) return 8'd255;
      if (p >= (longint'(288) <<< PROD_FRAC)) return 8'd0;
      conc = (p + (longint'(1) <<< (PROD_FRAC - 17))) >>> (PROD_FRAC - 16);
      t    = (longint'(255) <<< 16) - conc;
      e    = floor_div(t * log255, longint'(255) <<< 16);
      lo   = '0;
      for (int b = LVL_W - 1; b >= 0; b--) begin
        cand    = lo;
        cand[b] = 1'b1;
        if (e >= thr_lut[cand]) lo = cand;
      end
      return lo;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_COEF_H0, REG_COEF_H1, REG_COEF_H2,
        REG_COEF_E0, REG_COEF_E1, REG_COEF_E2: weight[idx] = coef_t'(data);
        REG_SWAP: swap_chan = data[0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      longint        d [3];
      longint        dk;
      longint        ph;
      longint        pe;
      stain_levels_t lv;
      d[0] = dens_lut[a];
      d[1] = dens_lut[b];
      d[2] = dens_lut[c];
      ph   = 0;
      pe   = 0;
      for (int k = 0; k < 3; k++) begin
        dk = swap_chan ? d[2-k] : d[k];
        ph = ph + longint'(weight[k]) * dk;
        pe = pe + longint'(weight[3+k]) * dk;
      end
      lv.hema  = to_level(ph);
      lv.eosin = to_level(pe);
      expected_levels = {expected_levels, lv};
    endfunction

    function void check_levels(logic [LVL_W-1:0] h, logic [LVL_W-1:0] e);
      stain_levels_t want;
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hema %0d eosin %0d",
                 $time, h, e);
        errors++;
      end else begin
        want = expected_levels.pop_front();
        if (h !== want.hema) begin
          $display("%0t: hema_level expected %0d actual %0d", $time, want.hema, h);
          errors++;
        end
        if (e !== want.eosin) begin
          $display("%0t: eosin_level expected %0d actual %0d", $time, want.eosin, e);
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [LVL_W-1:0]     in_chan_a;
  logic [LVL_W-1:0]     in_chan_b;
  logic [LVL_W-1:0]     in_chan_c;
  logic                 out_valid;
  logic                 out_stall;
  logic [LVL_W-1:0]     out_hema_level;
  logic [LVL_W-1:0]     out_eosin_level;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  stain_level_board sb;
  int               tx_idle_pct;
  int               rx_idle_pct;
  int               pix_sent;
  logic             rx_hold;

  stain_color_deconvolution_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_chan_a       (in_chan_a),
    .in_chan_b       (in_chan_b),
    .in_chan_c       (in_chan_c),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hema_level  (out_hema_level),
    .out_eosin_level (out_eosin_level),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("stain_color_deconvolution_unit test failed");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_levels(out_hema_level, out_eosin_level);
  end

  // long output hold-off so the pipeline fills and pushes back on the input
  initial begin
    rx_hold = 1'b0;
    wait (pix_sent >= HOLD_AT);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic send_pixel(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_chan_a <= a;
    in_chan_b <= b;
    in_chan_c <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(a, b, c);
    pix_sent++;
  endtask

  task automatic drain(input int extra);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (sb.expected_levels.size() != 0 && waited < DRAIN_LIMIT);
    if (sb.expected_levels.size() != 0) begin
      $display("%0t: %0d expected results never arrived, expected 0 pending, actual %0d",
               $time, sb.expected_levels.size(), sb.expected_levels.size());
      sb.errors++;
      sb.expected_levels.delete();
    end
    repeat (extra) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic load_weights(input coef_t w [6], input bit swap);
    logic [CFG_DAT_W-1:0] data;
    for (int i = 0; i < 6; i++) put_reg(WEIGHT_REG[i], w[i]);
    data    = CFG_DAT_W'($urandom);
    data[0] = swap;
    put_reg(REG_SWAP, data);
    put_reg(REG_SPARE, CFG_DAT_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic coef_t rand_weight(input int span);
    case ($urandom_range(2))
      0: return (span == 0) ? COEF_MIN : coef_t'(int'($urandom_range(2 * span)) - span);
      1: return (span == 0) ? COEF_MAX : coef_t'(int'($urandom_range(2 * span)) - span);
      default: return (span == 0) ? coef_t'(int'($urandom_range(8000)) - 4000)
                                  : coef_t'(int'($urandom_range(2 * span)) - span);
    endcase
  endfunction

  function automatic logic [23:0] rand_pixel();
    logic [23:0] px;
    int          sel;
    sel = $urandom_range(9);
    for (int k = 0; k < 3; k++) begin
      if (sel < 7) px[8*k +: 8] = 8'($urandom_range(255));
      else if (sel < 9) px[8*k +: 8] = 8'($urandom_range(255, 150));
      else begin
        case ($urandom_range(2))
          0: px[8*k +: 8] = 8'd0;
          1: px[8*k +: 8] = 8'd255;
          default: px[8*k +: 8] = 8'($urandom_range(255));
        endcase
      end
    end
    return px;
  endfunction

  initial begin
    coef_t       w [6];
    logic [23:0] px;
    int          span;
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_chan_a   = '0;
    in_chan_b   = '0;
    in_chan_c   = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    pix_sent    = 0;
    tx_idle_pct = 34;
    rx_idle_pct = 65;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset value: every concentration is zero
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd17, 8'd140, 8'd230);
    drain(LATENCY + 2);

    w = '{2000, 1500, 800, -1000, 3000, 500};
    load_weights(w, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd254, 8'd127);
    send_pixel(8'd200, 8'd150, 8'd220);
    send_pixel(8'd90, 8'd60, 8'd170);
    send_pixel(8'd240, 8'd230, 8'd250);
    send_pixel(8'd170, 8'd85, 8'd85);
    send_pixel(8'd85, 8'd170, 8'd170);
    drain(LATENCY + 2);

    // extreme weights, reversed channel order: saturation at both ends
    w = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN};
    load_weights(w, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd128);
    send_pixel(8'd37, 8'd90, 8'd255);
    drain(LATENCY + 2);

    for (int ph = 0; ph < PHASES; ph++) begin
      tx_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 65 : 0;
      rx_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 34 : 0;
      case (ph)
        0: span = 6000;
        1: span = 16000;
        2: span = 4000;
        3: span = 32767;
        4: span = 8000;
        default: span = 0;
      endcase
      for (int i = 0; i < 6; i++) begin
        if (ph == 3) w[i] = coef_t'($urandom);
        else w[i] = rand_weight(span);
      end
      load_weights(w, ph[0]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2) drain(0);
        px = rand_pixel();
        send_pixel(px[23:16], px[15:8], px[7:0]);
      end
      drain(LATENCY + 2);
    end

    drain(LATENCY + 4);
    if (sb.errors == 0) $display("stain_color_deconvolution_unit test passed");
    else $display("stain_color_deconvolution_unit test failed");
    $finish;
  end

endmodule
